/* sv/cpls_pkg.sv */
`default_nettype none

package cpls_pkg;

  // Field widths
  localparam int ERR_W      = 16;
  localparam int PID_W      = 17;
  localparam int DRV_W      = 17;
  localparam int PWR_W      = 14;
  localparam int BUF_W      = 10;
  localparam int CLAMP_W    = 15;
  localparam int FS_W       = 16;
  localparam int KNEE_W     = 16;
  localparam int LANES      = 4;

  // Scale factor format (unsigned, SCALE_FRAC_BITS fraction bits, max 1.0)
  localparam int SCALE_FRAC_BITS = 16;
  localparam int FACT_W          = SCALE_FRAC_BITS + 1;

  // Datapath widths
  localparam int MAG_W     = ERR_W;              // |err| <= 32768
  localparam int SUM_W     = MAG_W + 2;          // sum of four magnitudes
  localparam int DEN_W     = SUM_W;              // max(sum, knee)
  localparam int PROD1_W   = MAG_W + FS_W;       // |err| * full_scale
  localparam int PROD2_W   = PROD1_W + FACT_W;   // ... * factor
  localparam int QUO_W     = FS_W;               // quotient never exceeds full_scale
  localparam int DIV_CNT_W = $clog2(QUO_W);
  localparam logic [DIV_CNT_W-1:0] DIV_LAST = DIV_CNT_W'(QUO_W - 1);

  // Configuration port
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;
  localparam logic [CFG_IDX_W-1:0] CFG_POWER_THRESHOLD = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_OVERPOWER_CLAMP = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_FULL_SCALE      = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_ERROR_KNEE      = 3'd3;

  localparam logic [PWR_W-1:0]   RST_POWER_THRESHOLD = 14'd9600;
  localparam logic [CLAMP_W-1:0] RST_OVERPOWER_CLAMP = 15'd4096;
  localparam logic [FS_W-1:0]    RST_FULL_SCALE      = 16'd61536;
  localparam logic [KNEE_W-1:0]  RST_ERROR_KNEE      = 16'd1500;

  typedef struct packed {
    logic [PWR_W-1:0]   power_threshold;
    logic [CLAMP_W-1:0] overpower_clamp;
    logic [FS_W-1:0]    full_scale;
    logic [KNEE_W-1:0]  error_knee;
  } cfg_t;

  // Scale levels
  typedef enum logic [2:0] {
    LVL_ZERO,
    LVL_P05,
    LVL_P125,
    LVL_P25,
    LVL_P50,
    LVL_P75,
    LVL_P90,
    LVL_FULL
  } level_t;

  // Factor per level, rounded to nearest
  localparam logic [FACT_W-1:0] LVL_FACTOR [8] = '{
    FACT_W'(0),
    FACT_W'(((1 << SCALE_FRAC_BITS) + 10) / 20),
    FACT_W'(((1 << SCALE_FRAC_BITS) + 4) / 8),
    FACT_W'(((1 << SCALE_FRAC_BITS) + 2) / 4),
    FACT_W'(((1 << SCALE_FRAC_BITS) + 1) / 2),
    FACT_W'(((3 << SCALE_FRAC_BITS) + 2) / 4),
    FACT_W'(((9 << SCALE_FRAC_BITS) + 5) / 10),
    FACT_W'(1 << SCALE_FRAC_BITS)
  };

  // Controller states
  typedef enum logic [2:0] {
    S_IDLE,
    S_EVAL,
    S_MUL1,
    S_MUL2,
    S_DIV,
    S_FIN,
    S_OUT
  } state_t;

  // Controller to datapath
  typedef struct packed {
    logic load;
    logic eval;
    logic mul1;
    logic mul2;
    logic div_step;
    logic finish;
  } dp_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic over_power;
  } dp_stat_t;

endpackage

`default_nettype wire

/* sv/chassis_power_limit_scaler_core.sv */
`default_nettype none

// Channel  | Direction | Handshake            | Payload
// ---------+-----------+----------------------+-------------------------------------------
// in_      | input     | in_valid / in_ready  | error_one..four, pid_one..four, power, buf
// out_     | output    | out_valid / out_ready| drive_one..four, over_power
// cfg_     | input     | cfg_valid / cfg_ready| cfg_index, cfg_data
//
// Over power: the evaluate state writes the clamped drives, then out_valid rises.
// Under power: after the input transfer the controller steps through evaluate, two multiply
// states, the 16-step radix-2 restoring divider (one per motor, run in parallel) and a
// finish state before out_valid rises.
// One item at a time: in_ready returns the cycle after the result transfer.
// Synchronous active-low reset returns the controller to idle, the scale level to zero
// and the configuration registers to their defaults. cfg_ready is always high.

module chassis_power_limit_scaler_core (
  input  wire                                  clk,
  input  wire                                  rst_n,
  // input channel
  input  wire                                  in_valid,
  output logic                                 in_ready,
  input  wire signed [cpls_pkg::ERR_W-1:0]     in_error_one,
  input  wire signed [cpls_pkg::ERR_W-1:0]     in_error_two,
  input  wire signed [cpls_pkg::ERR_W-1:0]     in_error_three,
  input  wire signed [cpls_pkg::ERR_W-1:0]     in_error_four,
  input  wire signed [cpls_pkg::PID_W-1:0]     in_pid_one,
  input  wire signed [cpls_pkg::PID_W-1:0]     in_pid_two,
  input  wire signed [cpls_pkg::PID_W-1:0]     in_pid_three,
  input  wire signed [cpls_pkg::PID_W-1:0]     in_pid_four,
  input  wire        [cpls_pkg::PWR_W-1:0]     in_power_tenths,
  input  wire        [cpls_pkg::BUF_W-1:0]     in_buffer_energy,
  // result channel
  output logic                                 out_valid,
  input  wire                                  out_ready,
  output logic signed [cpls_pkg::DRV_W-1:0]    out_drive_one,
  output logic signed [cpls_pkg::DRV_W-1:0]    out_drive_two,
  output logic signed [cpls_pkg::DRV_W-1:0]    out_drive_three,
  output logic signed [cpls_pkg::DRV_W-1:0]    out_drive_four,
  output logic                                 out_over_power,
  // configuration
  input  wire                                  cfg_valid,
  output logic                                 cfg_ready,
  input  wire        [cpls_pkg::CFG_IDX_W-1:0] cfg_index,
  input  wire        [cpls_pkg::CFG_DATA_W-1:0] cfg_data
);

  cpls_pkg::cfg_t     cfg_r, cfg_nxt;
  cpls_pkg::dp_cmd_t  cmd;
  cpls_pkg::dp_stat_t stat;

  logic signed [cpls_pkg::ERR_W-1:0] err_in [cpls_pkg::LANES];
  logic signed [cpls_pkg::PID_W-1:0] pid_in [cpls_pkg::LANES];
  logic signed [cpls_pkg::DRV_W-1:0] drive  [cpls_pkg::LANES];

  // Configuration registers
  assign cfg_ready = 1'b1;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_valid) begin
      unique case (cfg_index)
        cpls_pkg::CFG_POWER_THRESHOLD:
          cfg_nxt.power_threshold = cfg_data[cpls_pkg::PWR_W-1:0];
        cpls_pkg::CFG_OVERPOWER_CLAMP:
          cfg_nxt.overpower_clamp = cfg_data[cpls_pkg::CLAMP_W-1:0];
        cpls_pkg::CFG_FULL_SCALE:
          cfg_nxt.full_scale = cfg_data[cpls_pkg::FS_W-1:0];
        cpls_pkg::CFG_ERROR_KNEE:
          cfg_nxt.error_knee = cfg_data[cpls_pkg::KNEE_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.power_threshold <= cpls_pkg::RST_POWER_THRESHOLD;
      cfg_r.overpower_clamp <= cpls_pkg::RST_OVERPOWER_CLAMP;
      cfg_r.full_scale      <= cpls_pkg::RST_FULL_SCALE;
      cfg_r.error_knee      <= cpls_pkg::RST_ERROR_KNEE;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  // Lane packing
  assign err_in[0] = in_error_one;
  assign err_in[1] = in_error_two;
  assign err_in[2] = in_error_three;
  assign err_in[3] = in_error_four;
  assign pid_in[0] = in_pid_one;
  assign pid_in[1] = in_pid_two;
  assign pid_in[2] = in_pid_three;
  assign pid_in[3] = in_pid_four;

  cpls_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .stat      (stat),
    .cmd       (cmd)
  );

  cpls_dp u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg        (cfg_r),
    .cmd        (cmd),
    .stat       (stat),
    .err_in     (err_in),
    .pid_in     (pid_in),
    .pwr_in     (in_power_tenths),
    .buf_in     (in_buffer_energy),
    .drive      (drive),
    .over_power (out_over_power)
  );

  assign out_drive_one   = drive[0];
  assign out_drive_two   = drive[1];
  assign out_drive_three = drive[2];
  assign out_drive_four  = drive[3];

endmodule

`default_nettype wire

/* sv/cpls_ctrl.sv */
`default_nettype none

module cpls_ctrl (
  input  wire                      clk,
  input  wire                      rst_n,
  input  wire                      in_valid,
  output logic                     in_ready,
  output logic                     out_valid,
  input  wire                      out_ready,
  input  cpls_pkg::dp_stat_t       stat,
  output cpls_pkg::dp_cmd_t        cmd
);

  cpls_pkg::state_t                   state_r, state_nxt;
  logic [cpls_pkg::DIV_CNT_W-1:0]     cnt_r, cnt_nxt;

  // State and divide step counter
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= cpls_pkg::S_IDLE;
      cnt_r   <= '0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

  // Next state
  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = '0;
    unique case (state_r)
      cpls_pkg::S_IDLE: begin
        if (in_valid) state_nxt = cpls_pkg::S_EVAL;
      end
      cpls_pkg::S_EVAL: begin
        state_nxt = stat.over_power ? cpls_pkg::S_OUT : cpls_pkg::S_MUL1;
      end
      cpls_pkg::S_MUL1: state_nxt = cpls_pkg::S_MUL2;
      cpls_pkg::S_MUL2: state_nxt = cpls_pkg::S_DIV;
      cpls_pkg::S_DIV: begin
        if (cnt_r == cpls_pkg::DIV_LAST) begin
          state_nxt = cpls_pkg::S_FIN;
        end else begin
          cnt_nxt = cnt_r + 1'b1;
        end
      end
      cpls_pkg::S_FIN: state_nxt = cpls_pkg::S_OUT;
      cpls_pkg::S_OUT: begin
        if (out_ready) state_nxt = cpls_pkg::S_IDLE;
      end
      default: state_nxt = cpls_pkg::S_IDLE;
    endcase
  end

  // Outputs
  always_comb begin
    cmd       = '0;
    in_ready  = 1'b0;
    out_valid = 1'b0;
    unique case (state_r)
      cpls_pkg::S_IDLE: begin
        in_ready = 1'b1;
        cmd.load = in_valid;
      end
      cpls_pkg::S_EVAL: cmd.eval     = 1'b1;
      cpls_pkg::S_MUL1: cmd.mul1     = 1'b1;
      cpls_pkg::S_MUL2: cmd.mul2     = 1'b1;
      cpls_pkg::S_DIV:  cmd.div_step = 1'b1;
      cpls_pkg::S_FIN:  cmd.finish   = 1'b1;
      cpls_pkg::S_OUT:  out_valid    = 1'b1;
      default: ;
    endcase
  end

`ifndef ASSERT_OFF
  a_accept_to_eval: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> (state_r == cpls_pkg::S_EVAL))
    else $error("transfer in did not start evaluation");

  a_div_length: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == cpls_pkg::S_DIV && cnt_r == cpls_pkg::DIV_LAST)
      |=> (state_r == cpls_pkg::S_FIN))
    else $error("divider did not finish after last step");

  a_result_source: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(state_r == cpls_pkg::S_EVAL || state_r == cpls_pkg::S_FIN))
    else $error("result raised without a write of the output registers");
`endif

endmodule

`default_nettype wire

/* sv/cpls_dp.sv */
`default_nettype none

module cpls_dp (
  input  wire                                   clk,
  input  wire                                   rst_n,
  input  cpls_pkg::cfg_t                        cfg,
  input  cpls_pkg::dp_cmd_t                     cmd,
  output cpls_pkg::dp_stat_t                    stat,
  input  wire signed [cpls_pkg::ERR_W-1:0]      err_in [cpls_pkg::LANES],
  input  wire signed [cpls_pkg::PID_W-1:0]      pid_in [cpls_pkg::LANES],
  input  wire        [cpls_pkg::PWR_W-1:0]      pwr_in,
  input  wire        [cpls_pkg::BUF_W-1:0]      buf_in,
  output logic signed [cpls_pkg::DRV_W-1:0]     drive [cpls_pkg::LANES],
  output logic                                  over_power
);

  // Captured item
  logic signed [cpls_pkg::ERR_W-1:0]  err_r [cpls_pkg::LANES];
  logic signed [cpls_pkg::PID_W-1:0]  pid_r [cpls_pkg::LANES];
  logic        [cpls_pkg::PWR_W-1:0]  pwr_r;
  logic        [cpls_pkg::BUF_W-1:0]  buf_r;

  // Working registers
  logic        [cpls_pkg::MAG_W-1:0]   mag_r  [cpls_pkg::LANES];
  logic                                neg_r  [cpls_pkg::LANES];
  logic        [cpls_pkg::DEN_W-1:0]   den_r;
  logic        [cpls_pkg::PROD1_W-1:0] p1_r   [cpls_pkg::LANES];
  logic        [cpls_pkg::DEN_W-1:0]   rem_r  [cpls_pkg::LANES];
  logic        [cpls_pkg::QUO_W-1:0]   quo_r  [cpls_pkg::LANES];
  logic signed [cpls_pkg::DRV_W-1:0]   drive_r [cpls_pkg::LANES];
  logic                                over_r;
  cpls_pkg::level_t                    level_r;

  // Combinational
  logic                                over_c;
  logic        [cpls_pkg::MAG_W-1:0]   mag_c   [cpls_pkg::LANES];
  logic        [cpls_pkg::SUM_W-1:0]   sum_c;
  logic        [cpls_pkg::DEN_W-1:0]   den_c;
  cpls_pkg::level_t                    level_c;
  logic signed [cpls_pkg::PID_W-1:0]   lim_c;
  logic signed [cpls_pkg::DRV_W-1:0]   clamp_c [cpls_pkg::LANES];
  logic        [cpls_pkg::FACT_W-1:0]  fact_c;
  logic        [cpls_pkg::PROD2_W-1:0] p2_c    [cpls_pkg::LANES];
  logic        [cpls_pkg::DEN_W:0]     rem_sh_c [cpls_pkg::LANES];
  logic                                ge_c    [cpls_pkg::LANES];
  logic        [cpls_pkg::DRV_W-1:0]   qext_c  [cpls_pkg::LANES];
  logic signed [cpls_pkg::DRV_W-1:0]   quo_s_c [cpls_pkg::LANES];

  assign over_c          = pwr_r > cfg.power_threshold;
  assign stat.over_power = over_c;

  // Magnitudes, error sum and denominator
  always_comb begin
    sum_c = '0;
    for (int i = 0; i < cpls_pkg::LANES; i++) begin
      mag_c[i] = err_r[i][cpls_pkg::ERR_W-1] ? cpls_pkg::MAG_W'(-err_r[i])
                                             : cpls_pkg::MAG_W'(err_r[i]);
      sum_c    = sum_c + cpls_pkg::SUM_W'(mag_c[i]);
    end
    den_c = (sum_c > cpls_pkg::SUM_W'(cfg.error_knee)) ? sum_c
                                                        : cpls_pkg::DEN_W'(cfg.error_knee);
  end

  // Scale level from buffer bands; 50..59 and above 60 hold
  always_comb begin
    level_c = level_r;
    if (buf_r >= 10'd40 && buf_r < 10'd50)      level_c = cpls_pkg::LVL_P90;
    else if (buf_r >= 10'd35 && buf_r < 10'd40) level_c = cpls_pkg::LVL_P75;
    else if (buf_r >= 10'd30 && buf_r < 10'd35) level_c = cpls_pkg::LVL_P50;
    else if (buf_r >= 10'd20 && buf_r < 10'd30) level_c = cpls_pkg::LVL_P25;
    else if (buf_r >= 10'd10 && buf_r < 10'd20) level_c = cpls_pkg::LVL_P125;
    else if (buf_r < 10'd10)                    level_c = cpls_pkg::LVL_P05;
    else if (buf_r == 10'd60)                   level_c = cpls_pkg::LVL_FULL;
  end

  // Over power clamp
  assign lim_c = $signed(cpls_pkg::PID_W'(cfg.overpower_clamp));
  always_comb begin
    for (int i = 0; i < cpls_pkg::LANES; i++) begin
      if (pid_r[i] < -lim_c)     clamp_c[i] = cpls_pkg::DRV_W'(-lim_c);
      else if (pid_r[i] > lim_c) clamp_c[i] = cpls_pkg::DRV_W'(lim_c);
      else                       clamp_c[i] = cpls_pkg::DRV_W'(pid_r[i]);
    end
  end

  // Second product, restoring divide step, signed result
  assign fact_c = cpls_pkg::LVL_FACTOR[level_r];
  always_comb begin
    for (int i = 0; i < cpls_pkg::LANES; i++) begin
      p2_c[i]     = cpls_pkg::PROD2_W'(p1_r[i]) * cpls_pkg::PROD2_W'(fact_c);
      rem_sh_c[i] = {rem_r[i], quo_r[i][cpls_pkg::QUO_W-1]};
      ge_c[i]     = rem_sh_c[i] >= {1'b0, den_r};
      qext_c[i]   = cpls_pkg::DRV_W'(quo_r[i]);
      quo_s_c[i]  = neg_r[i] ? $signed(-qext_c[i]) : $signed(qext_c[i]);
    end
  end

  // Input capture
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      err_r <= err_in;
      pid_r <= pid_in;
      pwr_r <= pwr_in;
      buf_r <= buf_in;
    end
  end

  // Scale level state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      level_r <= cpls_pkg::LVL_ZERO;
    end else if (cmd.eval && !over_c) begin
      level_r <= level_c;
    end
  end

  // Lane registers
  always_ff @(posedge clk) begin
    if (cmd.eval && !over_c) begin
      den_r <= den_c;
    end
    for (int i = 0; i < cpls_pkg::LANES; i++) begin
      if (cmd.eval && !over_c) begin
        mag_r[i] <= mag_c[i];
        neg_r[i] <= err_r[i][cpls_pkg::ERR_W-1];
      end
      if (cmd.mul1) begin
        p1_r[i] <= cpls_pkg::PROD1_W'(mag_r[i]) * cpls_pkg::PROD1_W'(cfg.full_scale);
      end
      // drop the fraction bits; the top half starts the remainder
      if (cmd.mul2) begin
        rem_r[i] <= cpls_pkg::DEN_W'(p2_c[i][cpls_pkg::SCALE_FRAC_BITS + cpls_pkg::PROD1_W - 1 :
                                             cpls_pkg::SCALE_FRAC_BITS + cpls_pkg::QUO_W]);
        quo_r[i] <= p2_c[i][cpls_pkg::SCALE_FRAC_BITS + cpls_pkg::QUO_W - 1 :
                            cpls_pkg::SCALE_FRAC_BITS];
      end else if (cmd.div_step) begin
        rem_r[i] <= ge_c[i] ? cpls_pkg::DEN_W'(rem_sh_c[i] - {1'b0, den_r})
                            : rem_sh_c[i][cpls_pkg::DEN_W-1:0];
        quo_r[i] <= {quo_r[i][cpls_pkg::QUO_W-2:0], ge_c[i]};
      end
    end
  end

  // Output registers
  always_ff @(posedge clk) begin
    if (cmd.eval && over_c) begin
      drive_r <= clamp_c;
      over_r  <= 1'b1;
    end else if (cmd.finish) begin
      for (int i = 0; i < cpls_pkg::LANES; i++) begin
        drive_r[i] <= (den_r == '0) ? '0 : quo_s_c[i];
      end
      over_r <= 1'b0;
    end
  end

  assign drive      = drive_r;
  assign over_power = over_r;

`ifndef ASSERT_OFF
  a_level_update: assert property (@(posedge clk) disable iff (!rst_n)
    ($past(rst_n) && !$stable(level_r)) |-> $past(cmd.eval && !over_c))
    else $error("scale level changed outside an under-power evaluation");
`endif

endmodule

`default_nettype wire
